// ----- rtl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared constants, tables and types of the STFT frame analyser: sizes, the
// Hann window and the Q15 twiddles, and the command word to the DFT engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

	localparam int NFFT   = 32;
	localparam int NWIN   = NFFT - 1;
	localparam int AW     = $clog2(NFFT);
	localparam int NBINS  = NFFT / 2 + 1;
	localparam int KW     = $clog2(NBINS);
	localparam int CW     = $clog2(NFFT + 2);
	localparam int XW     = 16;
	localparam int WW     = XW + 1;
	localparam int TWW    = 17;
	localparam int PW     = WW + TWW;
	localparam int ACCW   = PW + AW + 1;
	localparam int BW     = 24;
	localparam int POSW   = 32;
	localparam int HOPW   = 6;
	localparam int FRAMES_MAX = 2;

	localparam logic [HOPW-1:0] HOP_RESET = HOPW'(8);
	localparam logic [POSW-1:0] POS_LIMIT = {POSW{1'b1}} - POSW'(2 * NFFT);

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam longint Q30     = 64'sd1 << 30;
	localparam longint HALF_PI = 64'sd1686629713;

	typedef struct packed {
		logic          frame;
		logic          done;
		logic [AW-1:0] base;
		logic          last;
	} eng_cmd_t;

	typedef logic signed [XW-1:0]  win_tab_t [NFFT];
	typedef logic signed [TWW-1:0] tw_tab_t  [NFFT];

	// Cosine or sine of 2*pi*p/q in Q30, q being NWIN or NFFT. Quadrant
	// reduction followed by a truncated Taylor series; used at elaboration.
	function automatic longint trig_q30(input int p_in, input bit win, input bit want_sin);
		longint a;
		longint quad;
		longint rem;
		longint th;
		longint tc;
		longint ts;
		longint cc;
		longint ss;
		longint c;
		longint s;
		if (win) begin
			a    = 4 * longint'(p_in % NWIN);
			quad = a / NWIN;
			rem  = a % NWIN;
			th   = (HALF_PI * rem + NWIN / 2) / NWIN;
		end else begin
			a    = 4 * longint'(p_in % NFFT);
			quad = a / NFFT;
			rem  = a % NFFT;
			th   = (HALF_PI * rem + NFFT / 2) / NFFT;
		end
		cc = Q30;
		ss = th;
		tc = Q30;
		ts = th;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 2;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 6;
		cc = cc - tc; ss = ss - ts;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 12;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 20;
		cc = cc + tc; ss = ss + ts;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 30;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 42;
		cc = cc - tc; ss = ss - ts;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 56;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 72;
		cc = cc + tc; ss = ss + ts;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 90;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 110;
		cc = cc - tc; ss = ss - ts;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 132;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 156;
		cc = cc + tc; ss = ss + ts;
		tc = (tc * th) >>> 30; tc = ((tc * th) >>> 30) / 182;
		ts = (ts * th) >>> 30; ts = ((ts * th) >>> 30) / 210;
		cc = cc - tc; ss = ss - ts;
		if (cc < 0) cc = 0;
		if (cc > Q30) cc = Q30;
		if (ss < 0) ss = 0;
		if (ss > Q30) ss = Q30;
		case (quad % 4)
			0: begin c = cc;  s = ss;  end
			1: begin c = -ss; s = cc;  end
			2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
		return want_sin ? s : c;
	endfunction

	function automatic win_tab_t build_win();
		win_tab_t tab;
		longint   w;
		int       i;
		for (i = 0; i < NFFT; i++) begin
			w = (Q30 - trig_q30(i, 1'b1, 1'b0) + 32768) >>> 16;
			if (w > 32767) w = 32767;
			tab[i] = XW'(w);
		end
		return tab;
	endfunction

	function automatic tw_tab_t build_tw(input bit want_sin);
		tw_tab_t tab;
		int      i;
		for (i = 0; i < NFFT; i++) begin
			tab[i] = TWW'((trig_q30(i, 1'b0, want_sin) + 16384) >>> 15);
		end
		return tab;
	endfunction

	localparam win_tab_t WIN_TAB = build_win();
	localparam tw_tab_t  TW_COS  = build_tw(1'b0);
	localparam tw_tab_t  TW_SIN  = build_tw(1'b1);

endpackage

`default_nettype wire

// ----- rtl/sfa_ring.sv -----
// ----------------------------------------------------------------------------
// sfa_ring
// Sample ring of the last NFFT padded positions. Synchronous memory with a
// registered read; per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_ring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          we,
	input  logic [sfa_pkg::AW-1:0]        waddr,
	input  logic signed [sfa_pkg::XW-1:0] wdata,
	input  logic [sfa_pkg::AW-1:0]        raddr,
	output logic signed [sfa_pkg::XW-1:0] rdata
);
	import sfa_pkg::*;

	logic signed [XW-1:0] mem [NFFT];
	logic [NFFT-1:0]      vld_q;
	logic signed [XW-1:0] rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/sfa_engine.sv -----
// ----------------------------------------------------------------------------
// sfa_engine
// Windows one frame from the sample ring into the work memory, then runs a
// direct DFT per bin with one complex MAC and registers each bin word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfa_pkg::eng_cmd_t             cmd,
	output logic                          busy,
	output logic [sfa_pkg::AW-1:0]        ring_raddr,
	input  logic signed [sfa_pkg::XW-1:0] ring_rdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sfa_pkg::KW-1:0]        bin_index,
	output logic signed [sfa_pkg::BW-1:0] bin_real,
	output logic signed [sfa_pkg::BW-1:0] bin_imag,
	output logic                          frame_end,
	output logic                          done_res,
	output logic                          last
);
	import sfa_pkg::*;

	typedef enum logic [4:0] {
		E_IDLE = 5'b00001,
		E_WIN  = 5'b00010,
		E_DFT  = 5'b00100,
		E_EMIT = 5'b01000,
		E_DONE = 5'b10000
	} eng_state_t;

	eng_state_t            state_q;
	logic [CW-1:0]         cnt_q;
	logic [KW-1:0]         k_q;
	logic [AW-1:0]         m_q;
	logic [AW-1:0]         base_q;
	logic                  last_q;
	logic                  v_s1;
	logic                  v_s2;
	logic [AW-1:0]         idx_s1;
	logic [AW-1:0]         idx_s2;
	logic signed [2*XW-1:0] wprod_s2;
	logic signed [PW-1:0]  pre_s2;
	logic signed [PW-1:0]  pim_s2;
	logic signed [ACCW-1:0] acc_re_q;
	logic signed [ACCW-1:0] acc_im_q;
	logic signed [WW-1:0]  work_mem [NFFT];
	logic signed [WW-1:0]  work_rdata_q;
	logic signed [2*XW-1:0] wrnd;
	logic signed [WW-1:0]  xw;
	logic signed [ACCW-1:0] re_rnd;
	logic signed [ACCW-1:0] im_rnd;
	logic                  issue;
	logic                  work_we;
	logic                  out_free;
	logic                  top_bin;

	assign busy       = (state_q != E_IDLE);
	assign issue      = (state_q == E_WIN || state_q == E_DFT) && (cnt_q < CW'(NFFT));
	assign ring_raddr = base_q + cnt_q[AW-1:0];
	assign work_we    = v_s2 && (state_q == E_WIN);
	assign wrnd       = wprod_s2 + (2*XW)'(16384);
	assign xw         = WW'(wrnd >>> 15);
	assign re_rnd     = acc_re_q + ACCW'(16384);
	assign im_rnd     = acc_im_q + ACCW'(16384);
	assign out_free   = !out_valid || out_ready;
	assign top_bin    = (k_q == KW'(NBINS - 1));

	always_ff @(posedge clk) begin
		if (work_we) begin
			work_mem[idx_s2] <= xw;
		end
		work_rdata_q <= work_mem[cnt_q[AW-1:0]];
	end

	// Data path of the window and MAC pipeline; no reset needed.
	always_ff @(posedge clk) begin
		idx_s1   <= (state_q == E_DFT) ? m_q : cnt_q[AW-1:0];
		idx_s2   <= idx_s1;
		wprod_s2 <= ring_rdata * WIN_TAB[idx_s1];
		pre_s2   <= work_rdata_q * TW_COS[idx_s1];
		pim_s2   <= work_rdata_q * TW_SIN[idx_s1];
		if (state_q == E_IDLE && cmd.frame) begin
			base_q <= cmd.base;
			last_q <= cmd.last;
		end
		if (state_q == E_WIN) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (state_q == E_EMIT && out_free) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (state_q == E_DFT && v_s2) begin
			acc_re_q <= acc_re_q + ACCW'(pre_s2);
			acc_im_q <= acc_im_q - ACCW'(pim_s2);
		end
		if (state_q == E_EMIT && out_free) begin
			bin_index <= k_q;
			bin_real  <= re_rnd[15 +: BW];
			bin_imag  <= im_rnd[15 +: BW];
			frame_end <= top_bin;
			done_res  <= 1'b0;
			last      <= last_q && top_bin;
		end else if (state_q == E_DONE && out_free) begin
			bin_index <= '0;
			bin_real  <= '0;
			bin_imag  <= '0;
			frame_end <= 1'b0;
			done_res  <= 1'b1;
			last      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			m_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
				m_q   <= m_q + k_q[AW-1:0];
			end else if (state_q == E_WIN || state_q == E_DFT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					cnt_q <= '0;
					k_q   <= '0;
					m_q   <= '0;
					if (cmd.frame) begin
						state_q <= E_WIN;
					end else if (cmd.done) begin
						state_q <= E_DONE;
					end
				end
				E_WIN: begin
					// The last windowed word lands in the work memory in this cycle.
					if (cnt_q == CW'(NFFT + 1)) begin
						cnt_q   <= '0;
						m_q     <= '0;
						state_q <= E_DFT;
					end
				end
				E_DFT: begin
					if (cnt_q == CW'(NFFT + 1)) begin
						state_q <= E_EMIT;
					end
				end
				E_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						cnt_q     <= '0;
						m_q       <= '0;
						if (top_bin) begin
							state_q <= E_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= E_DFT;
						end
					end
				end
				E_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/stft_hann_frame_analyzer_unit.sv -----
// ----------------------------------------------------------------------------
// stft_hann_frame_analyzer_unit
// Short-time spectrum of a 16-bit signal: Hann-windowed 32-point frames,
// bins 0 to 16 emitted as signed 24-bit real and imaginary words.
// ----------------------------------------------------------------------------
// Usage. Input words (func, sample) arrive on in_valid/in_ready; a sample word
// with func low, a finish word with func high. Result words leave on
// out_valid/out_ready, one per bin, last marking the final word of an input.
// hop_size must be written through cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce it. in_ready is high only while idle, so a
// new word is not taken while the last one or its frames are in work. Each frame
// is windowed out of the sample ring into the work memory, then each bin runs
// through the single complex multiply-accumulate reading the work memory and its
// word is loaded into the output register. A finish word first writes up to hop
// zero samples, one per cycle.
// A sample word yields at most two frames; the rest follow with later words.
// After reset the ring reads as zero (valid bits) and hop_size is 8; a finish
// word that finds no frame left returns a done word and clears the block.
// When the receiver stalls the finished word waits in the output register and
// the engine holds before loading the next bin; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module stft_hann_frame_analyzer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfa_pkg::HOPW-1:0]        cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic signed [sfa_pkg::XW-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sfa_pkg::KW-1:0]          bin_index,
	output logic signed [sfa_pkg::BW-1:0]   bin_real,
	output logic signed [sfa_pkg::BW-1:0]   bin_imag,
	output logic                            frame_end,
	output logic                            done_res,
	output logic                            last
);
	import sfa_pkg::*;

	typedef enum logic [5:0] {
		T_IDLE  = 6'b000001,
		T_SCAN  = 6'b000010,
		T_WRITE = 6'b000100,
		T_FIN   = 6'b001000,
		T_FILL  = 6'b010000,
		T_WAIT  = 6'b100000
	} top_state_t;

	top_state_t           state_q, state_d;
	logic [POSW-1:0]      pos_q, pos_d;
	logic [POSW-1:0]      nfe_q, nfe_d;
	logic [POSW-1:0]      send_q, send_d;
	logic                 started_q, started_d;
	logic                 flush_q, flush_d;
	logic [1:0]           nfr_q, nfr_d;
	logic                 wrote_q, wrote_d;
	logic                 fin_q, fin_d;
	logic signed [XW-1:0] x_q, x_d;
	logic [HOPW-1:0]      hop_q;
	logic [HOPW-1:0]      hop_eff;
	logic [POSW-1:0]      nfe_nx;
	logic [POSW-1:0]      se;
	logic                 more;
	eng_cmd_t             cmd;
	logic                 eng_busy;
	logic                 ring_we;
	logic                 ring_clr;
	logic [AW-1:0]        ring_waddr;
	logic signed [XW-1:0] ring_wdata;
	logic [AW-1:0]        ring_raddr;
	logic signed [XW-1:0] ring_rdata;

	assign hop_eff = (hop_q == '0) ? HOPW'(1) : hop_q;
	assign nfe_nx  = nfe_q + POSW'(hop_eff);
	assign se      = flush_q ? send_q : pos_q;
	// Another frame follows within this word if the budget allows and the
	// next frame end lies below the position reached once the sample is in.
	assign more    = (32'(nfr_q) + 2 < FRAMES_MAX + 1) &&
	                 (wrote_q ? (nfe_nx < pos_q) : (nfe_nx <= pos_q));

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		nfe_d      = nfe_q;
		send_d     = send_q;
		started_d  = started_q;
		flush_d    = flush_q;
		nfr_d      = nfr_q;
		wrote_d    = wrote_q;
		fin_d      = fin_q;
		x_d        = x_q;
		cmd        = '0;
		ring_we    = 1'b0;
		ring_clr   = 1'b0;
		ring_waddr = pos_q[AW-1:0];
		ring_wdata = '0;
		in_ready   = 1'b0;
		case (state_q)
			T_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == FUNC_FINISH) begin
						fin_d   = 1'b1;
						state_d = T_FIN;
					end else if (!flush_q && pos_q < POS_LIMIT) begin
						started_d = 1'b1;
						x_d       = sample;
						nfr_d     = '0;
						wrote_d   = 1'b0;
						fin_d     = 1'b0;
						state_d   = T_SCAN;
					end
				end
			end
			T_SCAN: begin
				if (nfe_q < pos_q && 32'(nfr_q) < FRAMES_MAX) begin
					cmd.frame = 1'b1;
					cmd.base  = nfe_q[AW-1:0] + AW'(1);
					cmd.last  = !more;
					nfe_d     = nfe_nx;
					nfr_d     = nfr_q + 1'b1;
					state_d   = T_WAIT;
				end else if (!wrote_q) begin
					state_d = T_WRITE;
				end else begin
					state_d = T_IDLE;
				end
			end
			T_WRITE: begin
				ring_we    = 1'b1;
				ring_wdata = x_q;
				pos_d      = pos_q + 1'b1;
				wrote_d    = 1'b1;
				state_d    = T_SCAN;
			end
			T_FIN: begin
				if (started_q && !(nfe_q - POSW'(NFFT - 1) > se)) begin
					flush_d = 1'b1;
					send_d  = se;
					state_d = T_FILL;
				end else begin
					cmd.done  = 1'b1;
					ring_clr  = 1'b1;
					pos_d     = POSW'(NFFT);
					nfe_d     = POSW'(NFFT - 1);
					send_d    = '0;
					started_d = 1'b0;
					flush_d   = 1'b0;
					state_d   = T_WAIT;
				end
			end
			T_FILL: begin
				// Trailing padding goes in one zero word per cycle.
				if (pos_q <= nfe_q) begin
					ring_we = 1'b1;
					pos_d   = pos_q + 1'b1;
				end else begin
					cmd.frame = 1'b1;
					cmd.base  = nfe_q[AW-1:0] + AW'(1);
					cmd.last  = 1'b1;
					nfe_d     = nfe_nx;
					state_d   = T_WAIT;
				end
			end
			T_WAIT: begin
				if (!eng_busy) begin
					state_d = fin_q ? T_IDLE : T_SCAN;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			pos_q     <= POSW'(NFFT);
			nfe_q     <= POSW'(NFFT - 1);
			send_q    <= '0;
			started_q <= 1'b0;
			flush_q   <= 1'b0;
			nfr_q     <= '0;
			wrote_q   <= 1'b0;
			fin_q     <= 1'b0;
			hop_q     <= HOP_RESET;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			nfe_q     <= nfe_d;
			send_q    <= send_d;
			started_q <= started_d;
			flush_q   <= flush_d;
			nfr_q     <= nfr_d;
			wrote_q   <= wrote_d;
			fin_q     <= fin_d;
			if (cfg_we) begin
				hop_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_d;
	end

	sfa_ring u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (ring_clr),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	sfa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.busy      (eng_busy),
		.ring_raddr(ring_raddr),
		.ring_rdata(ring_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bin_index (bin_index),
		.bin_real  (bin_real),
		.bin_imag  (bin_imag),
		.frame_end (frame_end),
		.done_res  (done_res),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- rtl/sfa_checker.sv -----
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks of the STFT frame analyser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfa_pkg::HOPW-1:0]        cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            func,
	input  logic signed [sfa_pkg::XW-1:0]   sample,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [sfa_pkg::KW-1:0]          bin_index,
	input  logic signed [sfa_pkg::BW-1:0]   bin_real,
	input  logic signed [sfa_pkg::BW-1:0]   bin_imag,
	input  logic                            frame_end,
	input  logic                            done_res,
	input  logic                            last
);
	import sfa_pkg::*;

	// A stalled word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_real) && $stable(bin_imag)
		&& $stable(bin_index) && $stable(last))
		else $error("output word changed while stalled");

	// A done word carries no bin and closes its input word.
	a_done_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> last && !frame_end && bin_index == '0
		&& bin_real == '0 && bin_imag == '0)
		else $error("malformed done word");

	// Frame end marks the top bin and only that bin.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> (frame_end == (bin_index == KW'(NBINS - 1))))
		else $error("frame end flag on wrong bin");

	// An input word's results always end on a complete frame.
	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && !done_res |-> frame_end)
		else $error("last word inside a frame");

endmodule

bind stft_hann_frame_analyzer_unit sfa_checker u_sfa_checker (.*);

`default_nettype wire

// ----- sim/stft_hann_frame_analyzer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stft_hann_frame_analyzer_unit_test
// Self-checking bench for the STFT frame analyser. A queue-fed driver offers
// sample and finish words, a monitor takes the bin words and checks each one
// against a bit-exact software copy of the windowed DFT, over several hops.
// ----------------------------------------------------------------------------

module stft_hann_frame_analyzer_unit_test;

	import sfa_pkg::*;

	localparam int N     = 32;
	localparam int BINS  = N / 2 + 1;
	localparam int MAXB  = 34;

	typedef struct {
		logic        fn;
		logic [15:0] smp;
	} in_word_t;

	typedef struct {
		logic [4:0]  idx;
		logic [23:0] re;
		logic [23:0] im;
		logic        fe;
		logic        dn;
		logic        lst;
	} bin_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [HOPW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [15:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KW-1:0] bin_index;
	logic signed [BW-1:0] bin_real;
	logic signed [BW-1:0] bin_imag;
	logic frame_end, done_res, last;

	stft_hann_frame_analyzer_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .bin_index(bin_index),
		.bin_real(bin_real), .bin_imag(bin_imag), .frame_end(frame_end),
		.done_res(done_res), .last(last)
	);

	// Software copy of the block's state.
	longint    hann_w [N];
	longint    twc [N];
	longint    tws [N];
	longint    ring [N];
	longint    pos, nfe, sig_end;
	bit        started, flushing;
	int        hop_reg = 8;

	in_word_t  pend_q [$];
	bin_word_t bins_q [$];

	int send_idle = 33;
	int recv_idle = 82;
	int phase_no = 0;
	int hold_left = 0;
	bit hold_used = 1'b0;
	int errors = 0;
	int n_in = 0, n_res = 0, n_frames = 0, n_done = 0;

	// cos/sin of 2*pi*p/q in Q30: quadrant reduction, then a Taylor series.
	function automatic longint hann_trig(int p, int q, bit want_sin);
		longint a, quad, rem, th, tc, ts, cc, ss;
		int k;
		a    = 4 * longint'(p % q);
		quad = a / q;
		rem  = a % q;
		th   = (64'd1686629713 * rem + q / 2) / q;
		cc = 64'sd1 << 30;
		ss = th;
		tc = 64'sd1 << 30;
		ts = th;
		for (k = 1; k <= 7; k++) begin
			tc = (tc * th) >> 30;
			tc = ((tc * th) >> 30) / ((2 * k - 1) * (2 * k));
			ts = (ts * th) >> 30;
			ts = ((ts * th) >> 30) / ((2 * k) * (2 * k + 1));
			if (k % 2) begin cc -= tc; ss -= ts; end
			else begin cc += tc; ss += ts; end
		end
		if (cc < 0) cc = 0;
		if (cc > (64'sd1 << 30)) cc = 64'sd1 << 30;
		if (ss < 0) ss = 0;
		if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
		case (quad % 4)
			0: return want_sin ? ss : cc;
			1: return want_sin ? cc : -ss;
			2: return want_sin ? -ss : -cc;
			default: return want_sin ? -cc : ss;
		endcase
	endfunction

	function automatic longint rnd15(longint a);
		return (a + 16384) >>> 15;
	endfunction

	task automatic clear_signal();
		int i;
		for (i = 0; i < N; i++) ring[i] = 0;
		pos = N; nfe = N - 1; sig_end = 0;
		started = 0; flushing = 0;
	endtask

	task automatic push_frame(inout int cnt);
		longint xw [N];
		longint re, im, first;
		int n, k;
		bin_word_t bw;
		first = nfe - (N - 1);
		for (n = 0; n < N; n++) xw[n] = rnd15(ring[(first + n) % N] * hann_w[n]);
		for (k = 0; k < BINS; k++) begin
			re = 0; im = 0;
			for (n = 0; n < N; n++) begin
				re += xw[n] * twc[(k * n) % N];
				im -= xw[n] * tws[(k * n) % N];
			end
			bw = '{k[4:0], 24'(rnd15(re)), 24'(rnd15(im)),
				k == BINS - 1, 1'b0, 1'b0};
			bins_q.insert(bins_q.size(), bw);
		end
		nfe += (hop_reg == 0) ? 1 : hop_reg;
		cnt += BINS;
	endtask

	task automatic predict_word(in_word_t w);
		int cnt;
		bin_word_t dw;
		cnt = 0;
		if (w.fn == FUNC_SAMPLE) begin
			if (flushing || pos >= longint'(POS_LIMIT)) return;
			started = 1;
			while (nfe < pos && cnt + BINS <= MAXB) push_frame(cnt);
			ring[pos % N] = longint'($signed(w.smp));
			pos++;
			while (nfe < pos && cnt + BINS <= MAXB) push_frame(cnt);
		end else begin
			if (started && !flushing) begin
				flushing = 1;
				sig_end = pos;
			end
			if (!started || nfe - (N - 1) > sig_end) begin
				dw = '{5'd0, 24'd0, 24'd0, 1'b0, 1'b1, 1'b1};
				bins_q.insert(bins_q.size(), dw);
				clear_signal();
				return;
			end
			while (pos <= nfe) begin
				ring[pos % N] = 0;
				pos++;
			end
			push_frame(cnt);
		end
		if (cnt > 0) bins_q[bins_q.size() - 1].lst = 1'b1;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: presents the next pending word, predicting each one as it goes in.
	always @(posedge clk) begin
		in_word_t w;
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) begin
				predict_word('{func, sample});
				n_in++;
			end
			if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				w = pend_q.pop_front();
				in_valid <= 1'b1;
				func <= w.fn;
				sample <= w.smp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver stall, counted here, so the input side backs up.
	always @(posedge clk) begin
		if (phase_no == 2 && !hold_used) begin
			hold_left <= 4000;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks every accepted result word against the oldest expected one.
	always @(posedge clk) begin
		bin_word_t e;
		if (arst_n && out_valid && out_ready) begin
			n_res++;
			if (done_res) n_done++;
			if (frame_end) n_frames++;
			if (bins_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word: bin %0d", bin_index);
			end else begin
				e = bins_q.pop_front();
				if (e.idx !== bin_index || e.re !== bin_real || e.im !== bin_imag ||
				    e.fe !== frame_end || e.dn !== done_res || e.lst !== last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp bin %0d re %0d im %0d fe %b dn %b last %b, got bin %0d re %0d im %0d fe %b dn %b last %b",
							e.idx, $signed(e.re), $signed(e.im), e.fe, e.dn, e.lst,
							bin_index, bin_real, bin_imag, frame_end, done_res, last);
				end
			end
		end
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	task automatic add_word(logic fn, logic [15:0] v);
		in_word_t w;
		w = '{fn, v};
		pend_q.insert(pend_q.size(), w);
	endtask

	// A whole signal: random samples, then enough finish words to see done.
	// Noisy signals get a stray sample among the finishes, which is dropped.
	task automatic add_signal(int len, bit noisy);
		int i, h, nfin;
		h = (hop_reg == 0) ? 1 : hop_reg;
		for (i = 0; i < len; i++) add_word(FUNC_SAMPLE, 16'($urandom));
		nfin = (len + N) / h + 2;
		for (i = 0; i < nfin; i++) begin
			add_word(FUNC_FINISH, 16'($urandom));
			if (noisy && i == 0) add_word(FUNC_SAMPLE, 16'($urandom));
		end
	endtask

	task automatic settle();
		while (pend_q.size() != 0 || in_valid || bins_q.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_hop(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= HOPW'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		hop_reg = v;
	endtask

	task automatic fill_random(int count, int maxlen);
		while (pend_q.size() < count) add_signal($urandom_range(maxlen, 1), $urandom_range(3) == 0);
	endtask

	initial begin
		int i;
		for (i = 0; i < N; i++) begin
			hann_w[i] = ((64'sd1 << 30) - hann_trig(i, N - 1, 0) + 32768) >> 16;
			if (hann_w[i] > 32767) hann_w[i] = 32767;
			twc[i] = rnd15(hann_trig(i, N, 0));
			tws[i] = rnd15(hann_trig(i, N, 1));
		end
		clear_signal();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: finish on an empty signal, extreme samples, a sample
		// dropped while flushing, then finishes until done.
		add_word(FUNC_FINISH, 16'h0000);
		add_word(FUNC_SAMPLE, 16'h7FFF);
		add_word(FUNC_SAMPLE, 16'h8000);
		add_word(FUNC_SAMPLE, 16'h0000);
		add_word(FUNC_SAMPLE, 16'hFFFF);
		add_word(FUNC_SAMPLE, 16'h5555);
		add_word(FUNC_SAMPLE, 16'hAAAA);
		add_word(FUNC_FINISH, 16'hFFFF);
		add_word(FUNC_SAMPLE, 16'h1234);
		for (i = 0; i < 6; i++) add_word(FUNC_FINISH, 16'h0000);
		fill_random(30, 30);
		settle();

		// Hop of one: the first sample completes two frames.
		phase_no = 1;
		send_idle = 82; recv_idle = 33;
		write_hop(1);
		add_word(FUNC_SAMPLE, 16'h7FFF);
		fill_random(20, 4);
		settle();

		// Hop equal to the frame length with the long receiver stall; no idling.
		phase_no = 2;
		send_idle = 0; recv_idle = 0;
		write_hop(N);
		fill_random(25, 60);
		settle();

		phase_no = 3;
		write_hop(0);
		fill_random(16, 3);
		settle();

		// Hop above the frame length skips samples between frames.
		phase_no = 4;
		write_hop(63);
		fill_random(15, 40);
		settle();

		phase_no = 5;
		write_hop($urandom_range(32, 2));
		fill_random(15, 30);
		settle();

		$display("Covered %0d input words and %0d result words: %0d frames, %0d done words,",
			n_in, n_res, n_frames, n_done);
		$display("over hops 8, 1, 32, 0, 63 and a random one, with %0d mismatches.", errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sfa_pkg.sv
rtl/sfa_ring.sv
rtl/sfa_engine.sv
rtl/stft_hann_frame_analyzer_unit.sv
rtl/sfa_checker.sv
sim/stft_hann_frame_analyzer_unit_test.sv
